/* rtl/core/tfd_pkg.sv */
// Shared types and constants for the tensor frame deframer.
package tfd_pkg;

    localparam int unsigned COUNT_BITS_DEF = 64;

    // Header layout, byte offsets from the start of the frame
    localparam int unsigned HEADER_LEN = 20;
    localparam int unsigned MAGIC_AT   = 0;
    localparam int unsigned VERSION_AT = 4;
    localparam int unsigned META_AT    = 8;
    localparam int unsigned TENSOR_AT  = 12;
    localparam int unsigned SLOT_BITS  = $clog2(HEADER_LEN);

    localparam int unsigned CFG_INDEX_BITS = 8;
    localparam int unsigned CFG_DATA_BITS  = 48;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAGIC_WORD       = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_VERSION = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_METADATA_LEN = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_TENSOR_LEN   = 8'd3;

    typedef enum logic [1:0] {
        REGION_HEADER   = 2'd0,
        REGION_METADATA = 2'd1,
        REGION_TENSOR   = 2'd2
    } t_region;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_MAGIC     = 3'd2,
        STATUS_VERSION   = 3'd3,
        STATUS_META_LONG = 3'd4,
        STATUS_TENS_LONG = 3'd5,
        STATUS_SIZE      = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        t_region    region;
        logic       frame_done;
        t_status    status;
    } t_out_item;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [31:0] expected_version;
        logic [31:0] max_metadata_len;
        logic [47:0] max_tensor_len;
    } t_cfg;

endpackage

/* rtl/core/tfd_cfg_regs.sv */
// Configuration register file for the tensor frame deframer.
module tfd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [tfd_pkg::CFG_INDEX_BITS-1:0]  i_index,
    input  logic [tfd_pkg::CFG_DATA_BITS-1:0]   i_data,
    output tfd_pkg::t_cfg                       o_cfg
);

    tfd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word       <= '0;
            r_cfg.expected_version <= '0;
            r_cfg.max_metadata_len <= '1;
            r_cfg.max_tensor_len   <= '1;
        end else if (i_wr_en) begin
            case (i_index)
                tfd_pkg::CFG_MAGIC_WORD:       r_cfg.magic_word       <= i_data[31:0];
                tfd_pkg::CFG_EXPECTED_VERSION: r_cfg.expected_version <= i_data[31:0];
                tfd_pkg::CFG_MAX_METADATA_LEN: r_cfg.max_metadata_len <= i_data[31:0];
                tfd_pkg::CFG_MAX_TENSOR_LEN:   r_cfg.max_tensor_len   <= i_data[47:0];
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/tfd_parser.sv */
// Frame state, header capture, region tagging and frame verdict.
module tfd_parser #(
    parameter int unsigned COUNT_BITS = tfd_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  tfd_pkg::t_in_item  i_item,
    input  tfd_pkg::t_cfg      i_cfg,
    output tfd_pkg::t_out_item o_result
);

    localparam int unsigned HL = tfd_pkg::HEADER_LEN;
    localparam int unsigned SB = tfd_pkg::SLOT_BITS;

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [HL-1:0][7:0]    r_hdr;
    logic [HL-1:0][7:0]    hdr_now;

    logic                  hdr_pos;
    logic [SB-1:0]         slot;
    logic [COUNT_BITS-1:0] offset;
    logic [31:0]           magic;
    logic [31:0]           version;
    logic [31:0]           meta_len;
    logic [63:0]           tens_len;
    logic [63:0]           size;
    logic [63:0]           expected;
    tfd_pkg::t_status      status;
    tfd_pkg::t_region      region;

    assign hdr_pos = r_count < COUNT_BITS'(HL);
    assign slot    = r_count[SB-1:0];
    assign n_count = (r_count == '1) ? r_count : r_count + COUNT_BITS'(1);
    assign offset  = r_count - COUNT_BITS'(HL);

    // Header as it stands once this byte is in
    always_comb begin
        for (int i = 0; i < HL; i++) begin
            hdr_now[i] = (hdr_pos && slot == SB'(i)) ? i_item.data_byte : r_hdr[i];
        end
        for (int k = 0; k < 4; k++) begin
            magic[8*k +: 8]    = hdr_now[tfd_pkg::MAGIC_AT + k];
            version[8*k +: 8]  = hdr_now[tfd_pkg::VERSION_AT + k];
            meta_len[8*k +: 8] = hdr_now[tfd_pkg::META_AT + k];
        end
        for (int k = 0; k < 8; k++) begin
            tens_len[8*k +: 8] = hdr_now[tfd_pkg::TENSOR_AT + k];
        end
    end

    assign size     = 64'(n_count);
    assign expected = 64'(HL) + 64'(meta_len) + tens_len;

    always_comb begin
        if (hdr_pos) begin
            region = tfd_pkg::REGION_HEADER;
        end else if (offset < COUNT_BITS'(meta_len)) begin
            region = tfd_pkg::REGION_METADATA;
        end else begin
            region = tfd_pkg::REGION_TENSOR;
        end
    end

    always_comb begin
        if (!i_item.frame_end) begin
            status = tfd_pkg::STATUS_OK;
        end else if (size < 64'(HL)) begin
            status = tfd_pkg::STATUS_SHORT;
        end else if (magic != i_cfg.magic_word) begin
            status = tfd_pkg::STATUS_MAGIC;
        end else if (version != i_cfg.expected_version) begin
            status = tfd_pkg::STATUS_VERSION;
        end else if (meta_len > i_cfg.max_metadata_len) begin
            status = tfd_pkg::STATUS_META_LONG;
        end else if (tens_len > 64'(i_cfg.max_tensor_len)) begin
            status = tfd_pkg::STATUS_TENS_LONG;
        end else if (expected != size) begin
            status = tfd_pkg::STATUS_SIZE;
        end else begin
            status = tfd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hdr   <= '0;
        end else if (i_advance) begin
            if (i_item.frame_end) begin
                // clear for the next frame
                r_count <= '0;
                r_hdr   <= '0;
            end else begin
                r_count <= n_count;
                r_hdr   <= hdr_now;
            end
        end
    end

    assign o_result.payload_byte = i_item.data_byte;
    assign o_result.region       = region;
    assign o_result.frame_done   = i_item.frame_end;
    assign o_result.status       = status;

endmodule

/* rtl/core/tensor_frame_deframer.sv */
// Top level of the tensor frame deframer: input and result registers around the parser.
//
// Takes one frame byte per transaction and returns one result per byte: the byte, its
// region (header, metadata, tensor) and, on the byte flagged as last, the frame verdict.
// The block sustains one byte per clock cycle while the output is not stalled; each
// byte passes through the input register and then the result register, with header
// capture, the region compare and the verdict checks done between them. The byte
// counter saturates at 2^COUNT_BITS-1. Configuration registers are written through the
// cfg channel, which is always ready; write them only while no frame bytes are in flight.
module tensor_frame_deframer #(
    parameter int unsigned COUNT_BITS = tfd_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tfd_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tfd_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tfd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [tfd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    tfd_pkg::t_in_item  r_in;
    logic               r_in_valid;
    tfd_pkg::t_out_item r_out;
    logic               r_out_valid;
    tfd_pkg::t_out_item result;
    tfd_pkg::t_cfg      cfg;
    logic               move;

    assign o_cfg_ready = 1'b1;

    tfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    tfd_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (move),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // advance the held byte whenever the result register is free or draining
    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while both stages are full and stalled");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_done) |-> (o_out_data.status == tfd_pkg::STATUS_OK))
        else $error("verdict shown on a byte that does not end the frame");

    a_body_not_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_done &&
         o_out_data.region != tfd_pkg::REGION_HEADER)
        |-> (o_out_data.status != tfd_pkg::STATUS_SHORT))
        else $error("frame past the header reported as short");
`endif

endmodule
